// ===== hdl/lbw_pkg.sv =====
// shared constants and types for the bilinear warp unit
package lbw_pkg;

   localparam int MAX_OUT_LEN_DEF = 32;
   localparam int COEF_WIDTH_DEF  = 32;

   localparam int FIELD_WIDTH   = 32;
   localparam int INDEX_WIDTH   = 5;
   localparam int CSR_IDX_WIDTH = 1;
   localparam int CSR_DW        = 16;
   localparam int LEN_WIDTH     = 6;
   localparam int LAM_WIDTH     = 16;
   localparam int MUL_B_WIDTH   = 32;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OUT_LEN     = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_WARP_FACTOR = 1'b1;

   localparam logic [LEN_WIDTH-1:0] OUT_LEN_RESET = 6'd32;
   localparam logic [LAM_WIDTH-1:0] WARP_RESET    = 16'd0;
   localparam int MIN_LEN = 2;

   localparam int RND_LAM = 15;
   localparam int RND_SCL = 30;
   localparam logic signed [MUL_B_WIDTH-1:0] ONE_Q30 = 32'sh4000_0000;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SQR  = 6'b000010,
      ST_MA   = 6'b000100,
      ST_M2   = 6'b001000,
      ST_AC   = 6'b010000,
      ST_EMIT = 6'b100000
   } lbw_state_type;

endpackage

// ===== hdl/lbw_mul.sv =====
// shared signed multiplier with registered product and rounded views
module lbw_mul #(
   parameter int AW = lbw_pkg::COEF_WIDTH_DEF + 1,
   parameter int BW = lbw_pkg::MUL_B_WIDTH
) (
   input  logic                    clock,
   input  logic signed [AW-1:0]    mul_a,
   input  logic signed [BW-1:0]    mul_b,
   output logic signed [AW+BW-1:0] prod,
   output logic signed [AW+BW-1:0] prod_r15,
   output logic signed [AW+BW-1:0] prod_r30
);

   localparam int PW = AW + BW;
   localparam logic signed [PW-1:0] HALF_LAM = PW'(1) <<< (lbw_pkg::RND_LAM - 1);
   localparam logic signed [PW-1:0] HALF_SCL = PW'(1) <<< (lbw_pkg::RND_SCL - 1);

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round half up, floor after the bias
   assign prod     = prod_ff;
   assign prod_r15 = (prod_ff + HALF_LAM) >>> lbw_pkg::RND_LAM;
   assign prod_r30 = (prod_ff + HALF_SCL) >>> lbw_pkg::RND_SCL;

endmodule

// ===== hdl/lbw_store.sv =====
// coefficient store with per-entry valid bits, unwritten entries read as zero
module lbw_store #(
   parameter int DEPTH = lbw_pkg::MAX_OUT_LEN_DEF,
   parameter int DW    = lbw_pkg::COEF_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DW-1:0]            wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DW-1:0]            rd_data
);

   logic [DW-1:0]    mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DW-1:0]    rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lpc_bilinear_warp_unit.sv =====
// bilinear warp unit: sequencer over one shared multiplier and the coefficient store
// an input word runs through squaring lambda, then a multiply and an accumulate step
// per stored element, with one extra multiply for element one; busy meanwhile
// a word flagged last then streams len results, one per cycle, once its last accumulate is done
// sustained rate is set by the single multiplier; the receiver cannot stall
// synchronous reset clears the store, sets len 32 and lambda 0
module lpc_bilinear_warp_unit #(
   parameter int MAX_OUT_LEN = lbw_pkg::MAX_OUT_LEN_DEF,
   parameter int COEF_WIDTH  = lbw_pkg::COEF_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [lbw_pkg::FIELD_WIDTH-1:0] req_coefficient,
   input  logic                                   req_last_coeff,
   output logic                                   rsp_valid,
   output logic signed [lbw_pkg::FIELD_WIDTH-1:0] rsp_warped_coeff,
   output logic [lbw_pkg::INDEX_WIDTH-1:0]        rsp_coeff_index,
   output logic                                   rsp_last_out,
   input  logic                                   csr_wr_en,
   input  logic [lbw_pkg::CSR_IDX_WIDTH-1:0]      csr_index,
   input  logic [lbw_pkg::CSR_DW-1:0]             csr_wdata
);

   localparam int SW = (COEF_WIDTH > lbw_pkg::FIELD_WIDTH) ? lbw_pkg::FIELD_WIDTH : COEF_WIDTH;
   localparam int AW = SW + 1;
   localparam int BW = lbw_pkg::MUL_B_WIDTH;
   localparam int PW = AW + BW;
   localparam int CW = $clog2(MAX_OUT_LEN + 1);
   localparam int IW = $clog2(MAX_OUT_LEN);
   localparam int XW = (CW > lbw_pkg::INDEX_WIDTH) ? CW : lbw_pkg::INDEX_WIDTH;
   localparam int LW = lbw_pkg::LEN_WIDTH + 1;
   localparam logic signed [SW-1:0] SAT_HI = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = {1'b1, {(SW-1){1'b0}}};

   lbw_pkg::lbw_state_type state_ff, state_in;

   logic [lbw_pkg::LEN_WIDTH-1:0] out_len_ff;
   logic signed [lbw_pkg::LAM_WIDTH-1:0] lam_ff;

   logic [CW-1:0] m_ff, m_in, m_next, len_eff;
   logic signed [lbw_pkg::FIELD_WIDTH-1:0] x_ff, x_in;
   logic last_ff, last_in;
   logic signed [BW-1:0] s_ff, s_in;
   logic signed [PW-1:0] acc_ff, acc_in;
   logic signed [SW-1:0] newprev_ff, newprev_in;
   logic signed [SW-1:0] oldprev_ff, oldprev_in;
   logic signed [SW-1:0] oldcur_ff, oldcur_in;

   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW-1:0] prod, prod_r15, prod_r30;

   logic          st_clear, st_wr_en, st_rd_en;
   logic [IW-1:0] st_wr_addr, st_rd_addr;
   logic [SW-1:0] st_rd_data;
   logic signed [SW-1:0] rd_val;

   logic signed [PW-1:0] base, sum;
   logic signed [SW-1:0] sat_val;
   logic [LW-1:0]        len_wide;
   logic [XW-1:0]        idx_wide;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         out_len_ff <= lbw_pkg::OUT_LEN_RESET;
         lam_ff     <= lbw_pkg::WARP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            lbw_pkg::CSR_OUT_LEN: begin
               out_len_ff <= csr_wdata[lbw_pkg::LEN_WIDTH-1:0];
            end
            lbw_pkg::CSR_WARP_FACTOR: begin
               lam_ff <= csr_wdata[lbw_pkg::LAM_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective length, clamped
   assign len_wide = LW'(out_len_ff);
   always_comb begin
      if (len_wide < LW'(lbw_pkg::MIN_LEN)) begin
         len_eff = CW'(lbw_pkg::MIN_LEN);
      end else if (len_wide > LW'(MAX_OUT_LEN)) begin
         len_eff = CW'(MAX_OUT_LEN);
      end else begin
         len_eff = CW'(len_wide);
      end
   end

   assign m_next = m_ff + CW'(1);
   assign rd_val = $signed(st_rd_data);

   // accumulate and saturate
   always_comb begin
      if (m_ff == '0) begin
         base = PW'(x_ff);
      end else if (m_ff == CW'(1)) begin
         base = acc_ff;
      end else begin
         base = PW'(oldprev_ff);
      end
      sum = base + prod_r15;
      if (!sum[PW-1] && (|sum[PW-2:SW-1])) begin
         sat_val = SAT_HI;
      end else if (sum[PW-1] && !(&sum[PW-2:SW-1])) begin
         sat_val = SAT_LO;
      end else begin
         sat_val = sum[SW-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      m_in       = m_ff;
      x_in       = x_ff;
      last_in    = last_ff;
      s_in       = s_ff;
      acc_in     = acc_ff;
      newprev_in = newprev_ff;
      oldprev_in = oldprev_ff;
      oldcur_in  = oldcur_ff;
      mul_a      = '0;
      mul_b      = '0;
      st_clear   = 1'b0;
      st_wr_en   = 1'b0;
      st_rd_en   = 1'b0;
      st_wr_addr = m_ff[IW-1:0];
      st_rd_addr = m_ff[IW-1:0];
      case (state_ff)
         lbw_pkg::ST_IDLE: begin
            if (start) begin
               x_in     = req_coefficient;
               last_in  = req_last_coeff;
               m_in     = '0;
               state_in = lbw_pkg::ST_SQR;
            end
         end
         lbw_pkg::ST_SQR: begin
            mul_a      = AW'(lam_ff);
            mul_b      = BW'(lam_ff);
            st_rd_en   = 1'b1;
            st_rd_addr = '0;
            state_in   = lbw_pkg::ST_MA;
         end
         lbw_pkg::ST_MA: begin
            oldcur_in = rd_val;
            if (m_ff == '0) begin
               s_in     = lbw_pkg::ONE_Q30 - prod[BW-1:0];
               mul_a    = AW'(rd_val);
               mul_b    = BW'(lam_ff);
               state_in = lbw_pkg::ST_AC;
            end else if (m_ff == CW'(1)) begin
               mul_a    = AW'(oldprev_ff);
               mul_b    = s_ff;
               state_in = lbw_pkg::ST_M2;
            end else begin
               mul_a    = AW'(rd_val) - AW'(newprev_ff);
               mul_b    = BW'(lam_ff);
               state_in = lbw_pkg::ST_AC;
            end
         end
         lbw_pkg::ST_M2: begin
            acc_in   = prod_r30;
            mul_a    = AW'(oldcur_ff);
            mul_b    = BW'(lam_ff);
            state_in = lbw_pkg::ST_AC;
         end
         lbw_pkg::ST_AC: begin
            st_wr_en   = 1'b1;
            newprev_in = sat_val;
            oldprev_in = oldcur_ff;
            if (m_next < len_eff) begin
               st_rd_en   = 1'b1;
               st_rd_addr = m_next[IW-1:0];
               m_in       = m_next;
               state_in   = lbw_pkg::ST_MA;
            end else if (last_ff) begin
               st_rd_en   = 1'b1;
               st_rd_addr = '0;
               m_in       = '0;
               state_in   = lbw_pkg::ST_EMIT;
            end else begin
               state_in = lbw_pkg::ST_IDLE;
            end
         end
         lbw_pkg::ST_EMIT: begin
            if (m_next < len_eff) begin
               st_rd_en   = 1'b1;
               st_rd_addr = m_next[IW-1:0];
               m_in       = m_next;
            end else begin
               st_clear   = 1'b1;
               newprev_in = '0;
               state_in   = lbw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbw_pkg::ST_IDLE;
         m_ff     <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         m_ff     <= m_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      s_ff       <= s_in;
      acc_ff     <= acc_in;
      newprev_ff <= newprev_in;
      oldprev_ff <= oldprev_in;
      oldcur_ff  <= oldcur_in;
   end

   lbw_mul #(
      .AW (AW),
      .BW (BW)
   ) u_lbw_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .prod     (prod),
      .prod_r15 (prod_r15),
      .prod_r30 (prod_r30)
   );

   lbw_store #(
      .DEPTH (MAX_OUT_LEN),
      .DW    (SW)
   ) u_lbw_store (
      .clock   (clock),
      .reset   (reset),
      .clear   (st_clear),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (sat_val),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // result word
   assign idx_wide         = XW'(m_ff);
   assign busy             = (state_ff != lbw_pkg::ST_IDLE);
   assign rsp_valid        = (state_ff == lbw_pkg::ST_EMIT);
   assign rsp_warped_coeff = lbw_pkg::FIELD_WIDTH'(rd_val);
   assign rsp_coeff_index  = idx_wide[lbw_pkg::INDEX_WIDTH-1:0];
   assign rsp_last_out     = rsp_valid && (m_next == len_eff);

endmodule

// ===== hdl/lbw_checker.sv =====
// port-level checks for the bilinear warp unit
module lbw_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [lbw_pkg::INDEX_WIDTH-1:0]   rsp_coeff_index,
   input logic                              rsp_last_out
);

   // results only come out while a word is in work
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   // a frame streams without gaps and with rising index
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_out |=>
         rsp_valid && (rsp_coeff_index == $past(rsp_coeff_index) + 5'd1))
      else $error("result burst broken");

   // a frame starts at index zero
   a_first: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_coeff_index == '0))
      else $error("frame does not start at index zero");

   // the unit frees up right after the last word
   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_last_out |=> !busy)
      else $error("still busy after last word");

   // an accepted word makes the unit busy
   a_take: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not start work");

endmodule

bind lpc_bilinear_warp_unit lbw_checker u_lbw_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_coeff_index (rsp_coeff_index),
   .rsp_last_out    (rsp_last_out)
);

// ===== tb/sv/tb_lpc_bilinear_warp_unit.sv =====
// self-checking testbench for the bilinear warp unit with a built-in warp predictor
module tb_lpc_bilinear_warp_unit;

   typedef struct {
      logic signed [lbw_pkg::FIELD_WIDTH-1:0] coef;
      logic                                   last;
   } coeff_word_type;

   typedef struct {
      logic signed [lbw_pkg::FIELD_WIDTH-1:0] value;
      logic [lbw_pkg::INDEX_WIDTH-1:0]        index;
      logic                                   last;
   } warped_word_type;

   localparam int DRAIN_CYCLES = 100;
   localparam int GAP_PERCENT  = 10;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    start = 1'b0;
   logic                                    busy;
   logic signed [lbw_pkg::FIELD_WIDTH-1:0]  req_coefficient = '0;
   logic                                    req_last_coeff = 1'b0;
   logic                                    rsp_valid;
   logic signed [lbw_pkg::FIELD_WIDTH-1:0]  rsp_warped_coeff;
   logic [lbw_pkg::INDEX_WIDTH-1:0]         rsp_coeff_index;
   logic                                    rsp_last_out;
   logic                                    csr_wr_en = 1'b0;
   logic [lbw_pkg::CSR_IDX_WIDTH-1:0]       csr_index = '0;
   logic [lbw_pkg::CSR_DW-1:0]              csr_wdata = '0;

   coeff_word_type  pending_coeffs[$];
   warped_word_type pending_warped[$];
   longint          warp_store[lbw_pkg::MAX_OUT_LEN_DEF];
   logic [lbw_pkg::LEN_WIDTH-1:0]        len_reg = lbw_pkg::OUT_LEN_RESET;
   logic signed [lbw_pkg::LAM_WIDTH-1:0] lambda_reg = '0;
   int              error_count = 0;
   bit              no_gaps = 1'b0;
   coeff_word_type  next_word;
   warped_word_type seen_word;

   lpc_bilinear_warp_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_coefficient  (req_coefficient),
      .req_last_coeff   (req_last_coeff),
      .rsp_valid        (rsp_valid),
      .rsp_warped_coeff (rsp_warped_coeff),
      .rsp_coeff_index  (rsp_coeff_index),
      .rsp_last_out     (rsp_last_out),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint round_shift(longint p, int k);
      return (p + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint clip_word(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // one all-pass recursion pass; a word flagged last dumps the store and clears it
   function automatic void warp_step(logic signed [lbw_pkg::FIELD_WIDTH-1:0] coef, logic last);
      longint          prior[lbw_pkg::MAX_OUT_LEN_DEF];
      longint          lam;
      longint          scl;
      longint          prev;
      int              len;
      warped_word_type w;
      lam = longint'(lambda_reg);
      scl = (longint'(1) << lbw_pkg::RND_SCL) - lam * lam;
      if (len_reg < lbw_pkg::MIN_LEN) len = lbw_pkg::MIN_LEN;
      else if (len_reg > lbw_pkg::MAX_OUT_LEN_DEF) len = lbw_pkg::MAX_OUT_LEN_DEF;
      else len = int'(len_reg);
      prior = warp_store;
      prev = clip_word(longint'(coef) + round_shift(lam * prior[0], lbw_pkg::RND_LAM));
      warp_store[0] = prev;
      prev = clip_word(round_shift(scl * prior[0], lbw_pkg::RND_SCL) +
                       round_shift(lam * prior[1], lbw_pkg::RND_LAM));
      warp_store[1] = prev;
      for (int m = 2; m < len; m++) begin
         prev = clip_word(prior[m - 1] +
                          round_shift(lam * (prior[m] - prev), lbw_pkg::RND_LAM));
         warp_store[m] = prev;
      end
      if (last) begin
         for (int m = 0; m < len; m++) begin
            w.value = warp_store[m][lbw_pkg::FIELD_WIDTH-1:0];
            w.index = m[lbw_pkg::INDEX_WIDTH-1:0];
            w.last  = (m == len - 1);
            pending_warped.push_back(w);
         end
         for (int m = 0; m < lbw_pkg::MAX_OUT_LEN_DEF; m++) warp_store[m] = 0;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) warp_step(req_coefficient, req_last_coeff);
         if (!start || !busy) begin
            if (pending_coeffs.size() != 0 &&
                (no_gaps || $urandom_range(99) >= GAP_PERCENT)) begin
               next_word = pending_coeffs.pop_front();
               start <= 1'b1;
               req_coefficient <= next_word.coef;
               req_last_coeff <= next_word.last;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_warped.size() == 0) begin
            $error("unexpected result word: index %0d value %0d", rsp_coeff_index,
                   rsp_warped_coeff);
            error_count++;
         end else begin
            seen_word = pending_warped.pop_front();
            if (rsp_warped_coeff !== seen_word.value) begin
               $error("warped_coeff expected %0d got %0d", seen_word.value, rsp_warped_coeff);
               error_count++;
            end
            if (rsp_coeff_index !== seen_word.index) begin
               $error("coeff_index expected %0d got %0d", seen_word.index, rsp_coeff_index);
               error_count++;
            end
            if (rsp_last_out !== seen_word.last) begin
               $error("last_out expected %0d got %0d", seen_word.last, rsp_last_out);
               error_count++;
            end
         end
      end
   end

   task automatic add_word(logic signed [lbw_pkg::FIELD_WIDTH-1:0] c, logic l);
      coeff_word_type w;
      w.coef = c;
      w.last = l;
      pending_coeffs.push_back(w);
   endtask

   task automatic wait_idle();
      while (pending_coeffs.size() != 0 || start || pending_warped.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [lbw_pkg::CSR_IDX_WIDTH-1:0] idx,
                            logic [lbw_pkg::CSR_DW-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == lbw_pkg::CSR_OUT_LEN) len_reg = value[lbw_pkg::LEN_WIDTH-1:0];
      else lambda_reg = value[lbw_pkg::LAM_WIDTH-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [lbw_pkg::FIELD_WIDTH-1:0] rand_coeff();
      logic signed [lbw_pkg::FIELD_WIDTH-1:0] r;
      r = $urandom;
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3, 4, 5: return r;
         default: return r >>> $urandom_range(8, 24);
      endcase
   endfunction

   task automatic random_config();
      logic [lbw_pkg::CSR_DW-1:0] len_val;
      logic [lbw_pkg::CSR_DW-1:0] lam_val;
      case ($urandom_range(5))
         0: len_val = lbw_pkg::CSR_DW'(lbw_pkg::MIN_LEN);
         1: len_val = lbw_pkg::CSR_DW'(lbw_pkg::MAX_OUT_LEN_DEF);
         2: len_val = lbw_pkg::CSR_DW'($urandom_range(0, 63));
         default: len_val = lbw_pkg::CSR_DW'($urandom_range(2, 10));
      endcase
      case ($urandom_range(6))
         0: lam_val = 16'h7FFF;
         1: lam_val = 16'h8000;
         2: lam_val = 16'h8001;
         3: lam_val = 16'h0000;
         default: lam_val = lbw_pkg::CSR_DW'($urandom);
      endcase
      if ($urandom_range(1)) begin
         write_reg(lbw_pkg::CSR_OUT_LEN, len_val);
         write_reg(lbw_pkg::CSR_WARP_FACTOR, lam_val);
      end else begin
         write_reg(lbw_pkg::CSR_WARP_FACTOR, lam_val);
         write_reg(lbw_pkg::CSR_OUT_LEN, len_val);
      end
   endtask

   // frames of random size, sometimes cut off so the next settings land mid-frame
   task automatic random_phase(int count);
      int left;
      int flen;
      left = count;
      while (left > 0) begin
         flen = ($urandom_range(4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         for (int i = 0; i < flen; i++) add_word(rand_coeff(), i == flen - 1);
         left -= flen;
      end
      if ($urandom_range(3) == 0)
         repeat ($urandom_range(1, 3)) add_word(rand_coeff(), 1'b0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: plain copy with zero padding
      add_word(32'sh7FFF_FFFF, 1'b0);
      add_word(32'sh8000_0000, 1'b0);
      add_word(32'sh0000_0001, 1'b1);
      add_word(32'shFFFF_FFFF, 1'b1);
      wait_idle();

      // shortest length, lambda near one: truncation and saturation
      write_reg(lbw_pkg::CSR_OUT_LEN, 16'd2);
      write_reg(lbw_pkg::CSR_WARP_FACTOR, 16'h7FFF);
      repeat (3) add_word(32'sh7FFF_FFFF, 1'b0);
      add_word(32'sh8000_0000, 1'b0);
      add_word(32'sh1234_5678, 1'b1);
      wait_idle();

      // length below minimum, most negative lambda so the scale is zero
      write_reg(lbw_pkg::CSR_OUT_LEN, 16'd0);
      write_reg(lbw_pkg::CSR_WARP_FACTOR, 16'h8000);
      add_word(32'sh8000_0000, 1'b0);
      add_word(32'sh7FFF_FFFF, 1'b0);
      add_word(32'sh8000_0000, 1'b0);
      add_word(32'sh0010_0000, 1'b1);
      wait_idle();

      // length above maximum, then shortened in the middle of a frame
      write_reg(lbw_pkg::CSR_OUT_LEN, 16'd63);
      write_reg(lbw_pkg::CSR_WARP_FACTOR, 16'h8001);
      add_word(32'sh0010_0000, 1'b0);
      add_word(32'shFFF0_0000, 1'b0);
      wait_idle();
      write_reg(lbw_pkg::CSR_OUT_LEN, 16'd5);
      add_word(32'sh7FFF_FFFF, 1'b0);
      add_word(32'sh0000_0000, 1'b1);
      wait_idle();

      write_reg(lbw_pkg::CSR_OUT_LEN, 16'd1);
      write_reg(lbw_pkg::CSR_WARP_FACTOR, 16'h4000);
      add_word(32'sh0000_0001, 1'b0);
      add_word(32'shFFFF_FFFF, 1'b0);
      add_word(32'sh5555_5555, 1'b1);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         random_config();
         no_gaps = (phase == 3);
         random_phase(26);
         wait_idle();
         no_gaps = 1'b0;
      end

      if (error_count == 0 && pending_warped.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(12 * 1_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
